### hw/rtl/urrd_pkg.sv
// Shared types and constants for the UART receive ring with drain port.
package urrd_pkg;

	localparam int FUNC_W = 2;
	localparam int BYTE_W = 8;
	localparam int CNT_W  = 7;

	localparam logic [FUNC_W-1:0] FUNC_RECV  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_DRAIN = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

	typedef struct packed {
		logic recv;
		logic clear;
		logic start;
		logic marker;
		logic fetch;
		logic emit;
	} urrd_cmd_t;

	typedef struct packed {
		logic stop_now;
		logic last_pend;
		logic out_free;
	} urrd_sts_t;

endpackage

### hw/rtl/urrd_ctrl.sv
// Sequencer for receive, clear and drain requests.
module urrd_ctrl
	import urrd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic [FUNC_W-1:0] req_func,
	input  urrd_sts_t         sts,
	output urrd_cmd_t         cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_FETCH = 2'd1;
	localparam logic [1:0] ST_EMIT  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign req_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					case (req_func)
						FUNC_RECV:  cmd.recv = 1'b1;
						FUNC_CLEAR: cmd.clear = 1'b1;
						FUNC_DRAIN: begin
							cmd.start = 1'b1;
							state_d   = ST_FETCH;
						end
						default: ;
					endcase
				end
			end
			ST_FETCH: begin
				if (sts.out_free) begin
					if (sts.stop_now) begin
						cmd.marker = 1'b1;
						state_d    = ST_IDLE;
					end else begin
						cmd.fetch = 1'b1;
						state_d   = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = sts.last_pend ? ST_IDLE : ST_FETCH;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### hw/rtl/urrd_dp.sv
// Ring memory, indices, drain counter and output register.
module urrd_dp
	import urrd_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  urrd_cmd_t         cmd,
	output urrd_sts_t         sts,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic [CNT_W-1:0]  in_limit,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,
	output logic              m_tuser,
	output logic              m_tlast
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] IDX_LAST = AW'(DEPTH - 1);

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] rd_data_q;

	logic [AW-1:0]    wr_idx_q;
	logic [AW-1:0]    rd_idx_q;
	logic             wrapped_q;
	logic [AW-1:0]    ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] limit_q;
	logic             last_q;
	logic [CNT_W-1:0] rep_cnt_q;

	logic              out_vld_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_bv_q;
	logic              out_last_q;
	logic [CNT_W-1:0]  out_cnt_q;

	logic             drop;
	logic [AW-1:0]    wr_addr;
	logic [AW-1:0]    ptr_next;
	logic [CNT_W-1:0] cnt1;
	logic [CNT_W-1:0] cnt2;
	logic             ahead_end;
	logic             ahead_lim;

	assign drop      = (wr_idx_q == rd_idx_q) && wrapped_q;
	assign wr_addr   = drop ? '0 : wr_idx_q;
	assign ptr_next  = (ptr_q == IDX_LAST) ? '0 : ptr_q + 1'b1;
	assign cnt1      = cnt_q + 1'b1;
	assign cnt2      = cnt_q + 2'd2;
	assign ahead_end = (ptr_next == wr_idx_q);
	assign ahead_lim = (cnt2 >= limit_q);

	assign sts.stop_now  = (ptr_q == wr_idx_q) || (cnt1 >= limit_q);
	assign sts.last_pend = last_q;
	assign sts.out_free  = !out_vld_q || m_tready;

	always_ff @(posedge clk) begin
		if (cmd.recv) begin
			mem[wr_addr] <= in_byte;
		end
		rd_data_q <= mem[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q  <= '0;
			rd_idx_q  <= '0;
			wrapped_q <= 1'b0;
		end else if (cmd.clear) begin
			wr_idx_q  <= '0;
			rd_idx_q  <= '0;
			wrapped_q <= 1'b0;
		end else if (cmd.recv) begin
			if (drop) begin
				rd_idx_q <= '0;
			end
			if (wr_addr == IDX_LAST) begin
				wr_idx_q  <= '0;
				wrapped_q <= 1'b1;
			end else begin
				wr_idx_q  <= wr_addr + 1'b1;
				wrapped_q <= drop ? 1'b0 : wrapped_q;
			end
		end else if (cmd.marker) begin
			rd_idx_q <= wr_idx_q;
		end else if (cmd.emit) begin
			if (ptr_q == IDX_LAST) begin
				wrapped_q <= 1'b0;
			end
			if (last_q) begin
				rd_idx_q <= wr_idx_q;
			end
		end
	end

	// drain walk state
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			ptr_q   <= rd_idx_q;
			cnt_q   <= '0;
			limit_q <= in_limit;
		end else if (cmd.fetch) begin
			cnt_q     <= cnt1;
			last_q    <= ahead_end || ahead_lim;
			rep_cnt_q <= ahead_end ? cnt1 : cnt2;
		end else if (cmd.emit) begin
			ptr_q <= ptr_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.marker || cmd.emit) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.marker) begin
			out_byte_q <= '0;
			out_bv_q   <= 1'b0;
			out_last_q <= 1'b1;
			out_cnt_q  <= (ptr_q == wr_idx_q) ? cnt_q : cnt1;
		end else if (cmd.emit) begin
			out_byte_q <= rd_data_q;
			out_bv_q   <= 1'b1;
			out_last_q <= last_q;
			out_cnt_q  <= last_q ? rep_cnt_q : '0;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {1'b0, out_cnt_q, out_byte_q};
	assign m_tuser  = out_bv_q;
	assign m_tlast  = out_last_q;

	a_marker_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.marker |=> (m_tvalid && m_tlast && !m_tuser))
		else $error("empty marker not presented");

	a_emit_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (m_tvalid && m_tuser))
		else $error("drained byte not presented");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.marker || cmd.fetch || cmd.emit) |-> (!out_vld_q || m_tready))
		else $error("output register overwritten");

	a_mid_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (out_cnt_q == '0))
		else $error("count on non-final result");

endmodule

### hw/rtl/uart_rx_ring_drain_core.sv
// Drain read of a single-byte-wide slot; receive and clear requests are handled without leaving idle.
// Drain: the FETCH state loads an empty marker into the output register, or each byte passes
// FETCH then EMIT via the registered ring read port; both states wait while the output is held.
// Input is taken only while no drain is in progress; output register holds until taken.
// Reset (async, active low) empties the ring: indices and wrapped flag go to zero.
// Top level of the UART receive ring with drain port.
module uart_rx_ring_drain_core
	import urrd_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // rx_byte[7:0], read_limit[14:8], zero pad
	input  logic [1:0]  s_tuser,  // func[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // out_byte[7:0], read_count[14:8], zero pad
	output logic        m_tuser,  // byte_valid
	output logic        m_tlast   // last_of_run
);

	urrd_cmd_t cmd;
	urrd_sts_t sts;

	urrd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req_func  (s_tuser),
		.sts       (sts),
		.cmd       (cmd)
	);

	urrd_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_byte  (s_tdata[7:0]),
		.in_limit (s_tdata[14:8]),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

### sim/tb_top.sv
// Testbench for uart_rx_ring_drain_core: directed and random ring traffic checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
	import urrd_pkg::*;

	localparam int RING_DEPTH = 64;
	localparam int ITEMS      = 380;
	localparam int IDLE_LIMIT = 4000;
	localparam int TAIL_CYCLES = 24;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	typedef struct {
		logic [FUNC_W-1:0] func;
		logic [BYTE_W-1:0] rx;
		logic [CNT_W-1:0]  limit;
	} ring_req_t;

	typedef struct {
		logic [BYTE_W-1:0] data;
		logic              valid;
		logic              last;
		logic [CNT_W-1:0]  count;
	} drain_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	uart_rx_ring_drain_core #(.DEPTH(RING_DEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// predictor state
	logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
	logic [5:0]        wr_ptr = '0;
	logic [5:0]        rd_ptr = '0;
	logic              wrap_flag = 1'b0;

	ring_req_t   req_q[$];
	drain_beat_t drained_q[$];
	ring_req_t   cur_req;

	int err_cnt = 0;
	int n_recv = 0, n_drain = 0, n_clear = 0, n_unused = 0, n_overflow = 0;
	int n_bytes = 0, n_markers = 0, n_ring_wraps = 0;
	int burst_left = 0, gap_left = 0;
	int idle_cycles = 0;
	int cyc = 0;
	int ready_mode = 0;

	function automatic logic [5:0] ring_next(input logic [5:0] idx);
		return (idx == 6'(RING_DEPTH - 1)) ? 6'd0 : idx + 6'd1;
	endfunction

	task automatic ring_apply(input ring_req_t req);
		logic [5:0]  r;
		int          cnt;
		int          copied;
		drain_beat_t beat;
		case (req.func)
			FUNC_RECV: begin
				n_recv++;
				if (wr_ptr == rd_ptr && wrap_flag) begin
					wr_ptr = '0;
					rd_ptr = '0;
					wrap_flag = 1'b0;
					n_overflow++;
				end
				ring_mem[wr_ptr] = req.rx;
				if (wr_ptr == 6'(RING_DEPTH - 1)) begin
					wr_ptr = '0;
					wrap_flag = 1'b1;
				end else begin
					wr_ptr = wr_ptr + 6'd1;
				end
			end
			FUNC_CLEAR: begin
				n_clear++;
				wr_ptr = '0;
				rd_ptr = '0;
				wrap_flag = 1'b0;
			end
			FUNC_DRAIN: begin
				n_drain++;
				r = rd_ptr;
				cnt = 0;
				copied = 0;
				while (r != wr_ptr) begin
					cnt++;
					if (cnt >= int'(req.limit))
						break;
					beat.data = ring_mem[r];
					beat.valid = 1'b1;
					beat.last = 1'b0;
					beat.count = '0;
					drained_q.push_back(beat);
					copied++;
					if (r == 6'(RING_DEPTH - 1)) begin
						wrap_flag = 1'b0;
						n_ring_wraps++;
					end
					r = ring_next(r);
				end
				rd_ptr = wr_ptr;
				if (copied == 0) begin
					beat.data = '0;
					beat.valid = 1'b0;
					beat.last = 1'b1;
					beat.count = CNT_W'(cnt);
					drained_q.push_back(beat);
				end else begin
					drained_q[drained_q.size() - 1].last = 1'b1;
					drained_q[drained_q.size() - 1].count = CNT_W'(cnt);
				end
			end
			default: n_unused++;
		endcase
	endtask

	task automatic add_req(input logic [FUNC_W-1:0] func, input logic [BYTE_W-1:0] rx,
			input logic [CNT_W-1:0] limit);
		ring_req_t req;
		req.func = func;
		req.rx = rx;
		req.limit = limit;
		req_q.push_back(req);
	endtask

	task automatic add_random_limit_drain();
		logic [CNT_W-1:0] lim;
		case ($urandom_range(0, 4))
			0: lim = 7'd0;
			1: lim = 7'd1;
			2: lim = 7'd64;
			3: lim = 7'($urandom_range(2, 8));
			default: lim = 7'($urandom_range(0, 64));
		endcase
		add_req(FUNC_DRAIN, 8'($urandom), lim);
	endtask

	task automatic check_field(input string fld, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, fld, want, got);
			err_cnt++;
		end
	endtask

	// request driver: bursts with random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				ring_apply(cur_req);
			if (s_tvalid && !s_tready) begin
				// hold the request
			end else if (gap_left != 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (req_q.size() != 0) begin
				cur_req = req_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {1'b0, cur_req.limit, cur_req.rx};
				s_tuser <= cur_req.func;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result stall pattern: always ready, random or periodic, picked at random
	always @(posedge clk) begin
		cyc++;
		if (cyc % 256 == 0)
			ready_mode = $urandom_range(0, 2);
		case (ready_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			default: m_tready <= (cyc % 7 == 3);
		endcase
	end

	// result checker
	always @(posedge clk) begin : mon
		drain_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (drained_q.size() == 0) begin
				$display("%0t: unexpected result, got data 0x%02h valid %0b last %0b count %0d",
					$time, m_tdata[7:0], m_tuser, m_tlast, m_tdata[14:8]);
				err_cnt++;
			end else begin
				want = drained_q.pop_front();
				if (want.valid)
					n_bytes++;
				else
					n_markers++;
				check_field("out_byte", want.data, m_tdata[7:0]);
				check_field("byte_valid", want.valid, m_tuser);
				check_field("last_of_run", want.last, m_tlast);
				check_field("read_count", want.count, m_tdata[14:8]);
				check_field("tdata pad", 0, m_tdata[15]);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no request or result moved for %0d cycles, %0d results pending",
					$time, IDLE_LIMIT, drained_q.size());
				$display("** uart_rx_ring_drain_core: FAILED **");
				$finish;
			end
		end
	end

	initial begin : stim
		int n_live;
		int nrx;
		int pick;

		// directed
		add_req(FUNC_DRAIN, 8'h00, 7'd64);
		add_req(FUNC_RECV, 8'h00, 7'd0);
		add_req(FUNC_RECV, 8'hff, 7'd127);
		add_req(FUNC_RECV, 8'h01, 7'd64);
		add_req(FUNC_RECV, 8'hfe, 7'd0);
		add_req(FUNC_DRAIN, 8'hff, 7'd64);
		add_req(FUNC_RECV, 8'ha5, 7'd0);
		add_req(FUNC_RECV, 8'h5a, 7'd0);
		add_req(FUNC_RECV, 8'hc3, 7'd0);
		add_req(FUNC_DRAIN, 8'h00, 7'd0);
		add_req(FUNC_RECV, 8'h11, 7'd0);
		add_req(FUNC_RECV, 8'h22, 7'd0);
		add_req(FUNC_DRAIN, 8'h00, 7'd1);
		add_req(FUNC_RECV, 8'h80, 7'd0);
		add_req(FUNC_RECV, 8'h7f, 7'd0);
		add_req(FUNC_RECV, 8'h40, 7'd0);
		add_req(FUNC_RECV, 8'h3c, 7'd0);
		add_req(FUNC_DRAIN, 8'h00, 7'd3);
		add_req(FUNC_UNUSED, 8'($urandom), 7'($urandom_range(0, 64)));
		add_req(FUNC_RECV, 8'h99, 7'd0);
		add_req(FUNC_RECV, 8'h66, 7'd0);
		add_req(FUNC_CLEAR, 8'h00, 7'd64);
		add_req(FUNC_DRAIN, 8'h00, 7'd64);

		// random: receive runs, some filling or overrunning the ring, then a drain, clear or unused request
		n_live = req_q.size();
		while (n_live < ITEMS) begin
			nrx = ($urandom_range(0, 9) < 2) ? $urandom_range(62, 66) : $urandom_range(0, 20);
			repeat (nrx) add_req(FUNC_RECV, 8'($urandom), 7'($urandom_range(0, 64)));
			n_live += nrx + 1;
			pick = $urandom_range(0, 19);
			if (pick == 0) begin
				add_req(FUNC_CLEAR, 8'($urandom), 7'($urandom_range(0, 64)));
			end else if (pick == 1) begin
				add_req(FUNC_UNUSED, 8'($urandom), 7'($urandom_range(0, 64)));
				n_live--;
			end else begin
				add_random_limit_drain();
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		while (req_q.size() != 0 || s_tvalid || drained_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Requests: %0d receive, %0d drain, %0d clear, %0d unused; %0d ring overruns.",
			n_recv, n_drain, n_clear, n_unused, n_overflow);
		$display("Results: %0d bytes and %0d empty markers checked, %0d read wraps.",
			n_bytes, n_markers, n_ring_wraps);
		if (err_cnt == 0 && drained_q.size() == 0) begin
			$display("** uart_rx_ring_drain_core: PASSED **");
		end else begin
			$display("** uart_rx_ring_drain_core: FAILED **");
		end
		$finish;
	end

endmodule
